### hw/rtl/nec_ir_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// nec ir frame decoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// antecedent and consequent in the same cycle, checked outside reset
`define NIR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nec ir decoder check failed");

// consequent in the cycle after the antecedent, checked outside reset
`define NIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nec ir decoder check failed");

`endif

### hw/rtl/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// types, constants and the interval window compare of the nec ir decoder
// ----------------------------------------------------------------------------
`default_nettype none

package necir_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned BIT_IDX_W  = $clog2(FRAME_BITS);

  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam int unsigned RB_DEPTH = 2;
  localparam int unsigned RB_AW    = $clog2(RB_DEPTH);
  localparam int unsigned RB_CNT_W = $clog2(RB_DEPTH + 1);

  localparam logic [CNT_W-1:0] LEADER_RST    = 16'd13500;
  localparam logic [CNT_W-1:0] REPEAT_RST    = 16'd11250;
  localparam logic [CNT_W-1:0] ZERO_RST      = 16'd1120;
  localparam logic [CNT_W-1:0] ONE_RST       = 16'd2250;
  localparam logic [CNT_W-1:0] TOLERANCE_RST = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER    = 3'd0,
    REG_REPEAT    = 3'd1,
    REG_ZERO      = 3'd2,
    REG_ONE       = 3'd3,
    REG_TOLERANCE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  // window hits of one edge interval
  typedef struct packed {
    logic leader_hit;
    logic repeat_hit;
    logic zero_hit;
    logic one_hit;
  } edge_class_t;

  typedef struct packed {
    logic              is_repeat;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] command;
  } result_t;

  // open window nominal - tol < t < nominal + tol, without wrap
  function automatic logic in_window(input logic [CNT_W-1:0] t,
                                     input logic [CNT_W-1:0] nominal,
                                     input logic [CNT_W-1:0] tol);
    logic [CNT_W:0] t_sum;
    logic [CNT_W:0] n_sum;
    t_sum = {1'b0, t} + {1'b0, tol};
    n_sum = {1'b0, nominal} + {1'b0, tol};
    return (t_sum > {1'b0, nominal}) && ({1'b0, t} < n_sum);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/necir_cq.sv
// ----------------------------------------------------------------------------
// necir_cq
// short queue of classified edges between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module necir_cq
  import necir_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire edge_class_t wr_data,
  output logic             full,
  input  wire logic        rd_en,
  output edge_class_t      rd_data,
  output logic             empty
);

  edge_class_t         mem [CQ_DEPTH];
  logic [CQ_AW-1:0]    wr_ptr;
  logic [CQ_AW-1:0]    rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + CQ_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + CQ_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CQ_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CQ_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/necir_front.sv
// ----------------------------------------------------------------------------
// necir_front
// timing registers and window classification of each edge interval
// ----------------------------------------------------------------------------
`default_nettype none

module necir_front
  import necir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data,
  input  wire logic [CNT_W-1:0]     elapsed_count,
  output edge_class_t               edge_class
);

  logic [CNT_W-1:0] leader_nominal;
  logic [CNT_W-1:0] repeat_nominal;
  logic [CNT_W-1:0] zero_nominal;
  logic [CNT_W-1:0] one_nominal;
  logic [CNT_W-1:0] tolerance;
  cfg_reg_t         cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_nominal <= LEADER_RST;
      repeat_nominal <= REPEAT_RST;
      zero_nominal   <= ZERO_RST;
      one_nominal    <= ONE_RST;
      tolerance      <= TOLERANCE_RST;
    end else if (cfg_valid) begin
      // writes to unknown indexes are dropped
      unique case (cfg_sel)
        REG_LEADER:    leader_nominal <= cfg_data;
        REG_REPEAT:    repeat_nominal <= cfg_data;
        REG_ZERO:      zero_nominal   <= cfg_data;
        REG_ONE:       one_nominal    <= cfg_data;
        REG_TOLERANCE: tolerance      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    edge_class.leader_hit = in_window(elapsed_count, leader_nominal, tolerance);
    edge_class.repeat_hit = in_window(elapsed_count, repeat_nominal, tolerance);
    edge_class.zero_hit   = in_window(elapsed_count, zero_nominal, tolerance);
    edge_class.one_hit    = in_window(elapsed_count, one_nominal, tolerance);
  end

endmodule

`default_nettype wire

### hw/rtl/necir_back.sv
// ----------------------------------------------------------------------------
// necir_back
// frame state machine, bit assembly, frame check and result buffer
// ----------------------------------------------------------------------------
`default_nettype none

module necir_back
  import necir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cq_empty,
  input  wire edge_class_t       cq_data,
  output logic                   cq_pop,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   is_repeat,
  output logic [BYTE_W-1:0]      address,
  output logic [BYTE_W-1:0]      command
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [BIT_IDX_W-1:0]   bit_index;
  logic [BIT_IDX_W-1:0]   bit_index_next;
  logic [FRAME_BITS-1:0]  shift_word;
  logic [FRAME_BITS-1:0]  shift_word_next;
  logic [BYTE_W-1:0]      last_address;
  logic [BYTE_W-1:0]      last_command;

  logic                   step;
  logic                   bit_hit;
  logic                   last_bit;
  logic                   frame_ok;
  logic [FRAME_BITS-1:0]  word_set;
  logic                   emit;
  logic                   save_frame;
  result_t                res;

  result_t                rb [RB_DEPTH];
  logic [RB_AW-1:0]       rb_wr;
  logic [RB_AW-1:0]       rb_rd;
  logic [RB_CNT_W-1:0]    rb_cnt;
  logic                   rb_pop;
  logic                   rb_room;
  result_t                rb_head;

  assign empty   = (rb_cnt == '0);
  assign rb_pop  = pop && !empty;
  // a slot frees up in the same cycle when the head is taken
  assign rb_room = (rb_cnt != RB_CNT_W'(RB_DEPTH)) || rb_pop;
  assign step    = !cq_empty && rb_room;
  assign cq_pop  = step;

  assign bit_hit  = cq_data.zero_hit || cq_data.one_hit;
  assign last_bit = (bit_index == BIT_IDX_W'(FRAME_BITS - 1));

  always_comb begin
    word_set            = shift_word;
    // zero wins when both windows hit
    word_set[bit_index] = !cq_data.zero_hit;
  end

  assign frame_ok = (word_set[7:0] == ~word_set[15:8]) &&
                    (word_set[23:16] == ~word_set[31:24]);

  // next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        PH_LEADER: begin
          priority if (cq_data.leader_hit) begin
            phase_next = PH_DATA;
          end else if (cq_data.repeat_hit) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_LEADER;
          end
        end
        PH_DATA: begin
          priority if (!bit_hit) begin
            phase_next = PH_LEADER;
          end else if (last_bit) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_DATA;
          end
        end
        default: phase_next = PH_LEADER;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    bit_index_next  = bit_index;
    shift_word_next = shift_word;
    emit            = 1'b0;
    save_frame      = 1'b0;
    res.is_repeat   = 1'b0;
    res.address     = word_set[7:0];
    res.command     = word_set[23:16];
    if (step) begin
      unique case (phase)
        PH_LEADER: begin
          priority if (cq_data.leader_hit) begin
            bit_index_next = '0;
          end else if (cq_data.repeat_hit) begin
            emit          = 1'b1;
            res.is_repeat = 1'b1;
            res.address   = last_address;
            res.command   = last_command;
          end else begin
            // bad interval, keep waiting for a leader
            bit_index_next = bit_index;
          end
        end
        PH_DATA: begin
          if (bit_hit) begin
            shift_word_next = word_set;
            if (last_bit) begin
              bit_index_next = '0;
              emit           = frame_ok;
              save_frame     = frame_ok;
            end else begin
              bit_index_next = bit_index + BIT_IDX_W'(1);
            end
          end else begin
            // stored bits stay, only the index restarts
            bit_index_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_index    <= '0;
      shift_word   <= '0;
      last_address <= '0;
      last_command <= '0;
    end else begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift_word <= shift_word_next;
      if (save_frame) begin
        last_address <= res.address;
        last_command <= res.command;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rb[rb_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rb_wr  <= '0;
      rb_rd  <= '0;
      rb_cnt <= '0;
    end else begin
      if (emit) begin
        rb_wr <= rb_wr + RB_AW'(1);
      end
      if (rb_pop) begin
        rb_rd <= rb_rd + RB_AW'(1);
      end
      if (emit && !rb_pop) begin
        rb_cnt <= rb_cnt + RB_CNT_W'(1);
      end else if (rb_pop && !emit) begin
        rb_cnt <= rb_cnt - RB_CNT_W'(1);
      end
    end
  end

  assign rb_head   = rb[rb_rd];
  assign is_repeat = rb_head.is_repeat;
  assign address   = rb_head.address;
  assign command   = rb_head.command;

endmodule

`default_nettype wire

### hw/rtl/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// nec infrared frame decoder, one input item per falling edge of the ir line
// ----------------------------------------------------------------------------
// input: push an edge with elapsed_count (timer counts since the previous
//   edge) whenever full is low; a transfer happens when push is high and full
//   is low. one edge can be taken every cycle.
// output: while empty is low the oldest result (is_repeat, address, command)
//   is on the ports; pop takes it. a full frame with good check bytes gives a
//   frame result, a repeat interval gives the last frame's address and command.
// datapath: the front classifies an edge against the four timing windows in
//   its transfer cycle and writes it into a four-entry queue; the back state
//   machine consumes one queued edge per cycle while the result buffer has room,
//   and each result is registered in that buffer before it shows on the ports.
//   sustained rate is one edge per cycle, set by the state machine step.
// stall: when pop stays low the two-entry result buffer fills, the back stops
//   taking edges, the queue fills and full rises; nothing is dropped.
// config: cfg_valid / cfg_ready (always ready) writes the timing registers,
//   meant only while the decoder is quiet.
// reset: rst (synchronous) loads the default timings, clears the queues and
//   puts the decoder in idle with a last frame of address 0, command 0.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_frame_decoder
  import necir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [CNT_W-1:0]     elapsed_count,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      is_repeat,
  output logic [BYTE_W-1:0]         address,
  output logic [BYTE_W-1:0]         command,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  edge_class_t edge_class;
  edge_class_t cq_data;
  logic        cq_empty;
  logic        cq_pop;

  necir_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .elapsed_count (elapsed_count),
    .edge_class    (edge_class)
  );

  necir_cq u_cq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (edge_class),
    .full    (full),
    .rd_en   (cq_pop),
    .rd_data (cq_data),
    .empty   (cq_empty)
  );

  necir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cq_empty  (cq_empty),
    .cq_data   (cq_data),
    .cq_pop    (cq_pop),
    .empty     (empty),
    .pop       (pop),
    .is_repeat (is_repeat),
    .address   (address),
    .command   (command)
  );

endmodule

`default_nettype wire

### hw/rtl/necir_checker.sv
// ----------------------------------------------------------------------------
// necir_checker
// port level checks of the nec ir decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "nec_ir_frame_decoder_assert.svh"

module necir_checker
  import necir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              full,
  input  wire logic              empty,
  input  wire logic              pop,
  input  wire logic              is_repeat,
  input  wire logic [BYTE_W-1:0] address,
  input  wire logic [BYTE_W-1:0] command
);

  // no result survives reset
  `NIR_ASSERT_NOW(a_empty_after_rst, $past(rst), empty)

  // the edge queue comes out of reset with room
  `NIR_ASSERT_NOW(a_room_after_rst, $past(rst), !full)

  // a waiting result holds until its transfer
  `NIR_ASSERT_NEXT(a_result_hold, !empty && !pop,
    !empty && $stable(is_repeat) && $stable(address) && $stable(command))

endmodule

bind nec_ir_frame_decoder necir_checker u_necir_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .is_repeat (is_repeat),
  .address   (address),
  .command   (command)
);

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the nec ir frame decoder: edge intervals go in
// through the push side, decoded frame and repeat results are popped and
// compared field by field against a cycle-free model of the decode rules,
// across several timing settings and idle/stall mixes
// ----------------------------------------------------------------------------
`default_nettype none

import necir_pkg::*;

class ir_frame_scoreboard;
  logic [CNT_W-1:0]      leader_nom;
  logic [CNT_W-1:0]      repeat_nom;
  logic [CNT_W-1:0]      zero_nom;
  logic [CNT_W-1:0]      one_nom;
  logic [CNT_W-1:0]      tol;
  phase_t                phase;
  logic [BIT_IDX_W-1:0]  bit_pos;
  logic [FRAME_BITS-1:0] frame_bits;
  logic [BYTE_W-1:0]     last_addr;
  logic [BYTE_W-1:0]     last_cmd;
  result_t               pending_results[$];
  int                    mismatches;
  int                    frames_seen;
  int                    repeats_seen;

  function new();
    leader_nom   = LEADER_RST;
    repeat_nom   = REPEAT_RST;
    zero_nom     = ZERO_RST;
    one_nom      = ONE_RST;
    tol          = TOLERANCE_RST;
    phase        = PH_IDLE;
    bit_pos      = '0;
    frame_bits   = '0;
    last_addr    = '0;
    last_cmd     = '0;
    mismatches   = 0;
    frames_seen  = 0;
    repeats_seen = 0;
  endfunction

  // open window around the nominal, evaluated in int so nothing wraps
  function bit hits(input logic [CNT_W-1:0] t, input logic [CNT_W-1:0] nom);
    return (int'(t) + int'(tol) > int'(nom)) && (int'(t) < int'(nom) + int'(tol));
  endfunction

  function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    case (idx)
      REG_LEADER:    leader_nom = val;
      REG_REPEAT:    repeat_nom = val;
      REG_ZERO:      zero_nom   = val;
      REG_ONE:       one_nom    = val;
      REG_TOLERANCE: tol        = val;
      default:       ;
    endcase
  endfunction

  function void add_result(input logic rep, input logic [BYTE_W-1:0] a,
                           input logic [BYTE_W-1:0] c);
    result_t r;
    r.is_repeat = rep;
    r.address   = a;
    r.command   = c;
    pending_results.push_back(r);
  endfunction

  // advance the decode state by one accepted edge
  function void note_edge(input logic [CNT_W-1:0] t);
    logic [BYTE_W-1:0] b0, b1, b2, b3;
    case (phase)
      PH_LEADER: begin
        if (hits(t, leader_nom)) begin
          phase   = PH_DATA;
          bit_pos = '0;
        end else if (hits(t, repeat_nom)) begin
          phase = PH_IDLE;
          add_result(1'b1, last_addr, last_cmd);
        end
      end
      PH_DATA: begin
        if (hits(t, zero_nom)) begin
          frame_bits[bit_pos] = 1'b0;
        end else if (hits(t, one_nom)) begin
          frame_bits[bit_pos] = 1'b1;
        end else begin
          // bits already stored are kept
          bit_pos = '0;
          phase   = PH_LEADER;
          return;
        end
        if (bit_pos != BIT_IDX_W'(FRAME_BITS - 1)) begin
          bit_pos = bit_pos + 1'b1;
        end else begin
          bit_pos = '0;
          phase   = PH_IDLE;
          b0 = frame_bits[7:0];
          b1 = ~frame_bits[15:8];
          b2 = frame_bits[23:16];
          b3 = ~frame_bits[31:24];
          if (b0 == b1 && b2 == b3) begin
            last_addr = b0;
            last_cmd  = b2;
            add_result(1'b0, b0, b2);
          end
        end
      end
      default: phase = PH_LEADER;
    endcase
  endfunction

  function void report(input string what, input int e, input int a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, actual %0h", what, e, a);
  endfunction

  function void check_result(input logic rep, input logic [BYTE_W-1:0] a,
                             input logic [BYTE_W-1:0] c);
    result_t e;
    if (pending_results.size() == 0) begin
      report("unexpected result (is_repeat)", 0, rep);
      return;
    end
    e = pending_results.pop_front();
    if (e.is_repeat) repeats_seen++;
    else frames_seen++;
    if (rep !== e.is_repeat) report("is_repeat", e.is_repeat, rep);
    if (a !== e.address) report("address", e.address, a);
    if (c !== e.command) report("command", e.command, c);
  endfunction
endclass

module tb_top;

  localparam int CNT_MAX      = (1 << CNT_W) - 1;
  localparam int CFG_IDX_MAX  = (1 << CFG_IDX_W) - 1;
  localparam int QUIET_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int TIMEOUT      = 3_000_000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 push          = 1'b0;
  logic                 full;
  logic [CNT_W-1:0]     elapsed_count = '0;
  logic                 empty;
  logic                 pop           = 1'b0;
  logic                 is_repeat;
  logic [BYTE_W-1:0]    address;
  logic [BYTE_W-1:0]    command;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CNT_W-1:0]     cfg_data      = '0;

  ir_frame_scoreboard sb = new();

  int  gap_pct     = 0;
  int  stall_pct   = 0;
  bit  hold_req    = 1'b0;
  int  holds_done  = 0;
  int  items_sent  = 0;
  int  cfg_writes  = 0;
  int  full_cycles = 0;

  nec_ir_frame_decoder uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("timeout with %0d results outstanding", sb.pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (full) full_cycles++;
      if (pop && !empty) sb.check_result(is_repeat, address, command);
    end
  end

  task automatic set_mode(input idle_mode_t m);
    case (m)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 76; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 76; end
      default:       begin gap_pct = 6;  stall_pct = 6;  end
    endcase
  endtask

  task automatic send_edge(input logic [CNT_W-1:0] t);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    elapsed_count <= t;
    do @(posedge clk); while (full);
    // an edge taken while idle only arms the decoder
    if (sb.phase != PH_IDLE) items_sent++;
    sb.note_edge(t);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic set_timing(input int ld, input int rp, input int zr, input int on,
                            input int tl);
    write_reg(REG_LEADER, CNT_W'(ld));
    write_reg(REG_REPEAT, CNT_W'(rp));
    write_reg(REG_ZERO, CNT_W'(zr));
    write_reg(REG_ONE, CNT_W'(on));
    write_reg(REG_TOLERANCE, CNT_W'(tl));
    // indexes past the register list must be ignored
    for (int i = int'(REG_TOLERANCE) + 1; i <= CFG_IDX_MAX; i++)
      write_reg(CFG_IDX_W'(i), CNT_W'($urandom_range(0, CNT_MAX)));
    cfg_valid <= 1'b0;
  endtask

  // stop offering edges and let every expected result and queued edge drain
  task automatic wait_quiet();
    push <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // random interval strictly inside the window around nom, or nom when the window is empty
  function automatic logic [CNT_W-1:0] near(input logic [CNT_W-1:0] nom);
    int lo, hi;
    lo = int'(nom) - int'(sb.tol) + 1;
    hi = int'(nom) + int'(sb.tol) - 1;
    if (lo < 0) lo = 0;
    if (hi > CNT_MAX) hi = CNT_MAX;
    if (lo > hi) return nom;
    return CNT_W'($urandom_range(hi, lo));
  endfunction

  task automatic reach_leader();
    while (sb.phase != PH_LEADER) send_edge(CNT_W'($urandom_range(0, CNT_MAX)));
  endtask

  task automatic send_frame();
    logic [BYTE_W-1:0]     a, c;
    logic [FRAME_BITS-1:0] word;
    int                    flaw, cut;
    a    = BYTE_W'($urandom);
    c    = BYTE_W'($urandom);
    word = {~c, c, ~a, a};
    flaw = $urandom_range(0, 9);
    cut  = $urandom_range(0, FRAME_BITS - 1);
    if (flaw == 1) word[cut] = ~word[cut];
    reach_leader();
    send_edge(near(sb.leader_nom));
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (flaw == 0 && i == cut) begin
        send_edge(CNT_W'($urandom_range(0, CNT_MAX)));
        return;
      end
      send_edge(near(word[i] ? sb.one_nom : sb.zero_nom));
    end
  endtask

  task automatic run_random(input int count, input bit with_hold);
    int start, pick;
    bit held;
    start = items_sent;
    held  = 1'b0;
    while (items_sent < start + count) begin
      if (with_hold && !held && items_sent >= start + count / 2) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame();
      end else if (pick < 80) begin
        reach_leader();
        send_edge(near(sb.repeat_nom));
      end else begin
        repeat ($urandom_range(1, 4)) send_edge(CNT_W'($urandom_range(0, CNT_MAX)));
      end
    end
    wait_quiet();
  endtask

  initial begin
    logic [CNT_W-1:0] directed_edges[$];

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_mode(IDLE_NONE);

    // default timings: arming, repeat before any frame, window edges,
    // bad intervals while awaiting a leader and inside data
    directed_edges = '{16'd65535, 16'd11250, 16'd0, 16'd0, 16'd65535, 16'd13000,
                       16'd13001, 16'd620, 16'd13999, 16'd621, 16'd2749, 16'd1619,
                       16'd1750, 16'd11749, 16'd14000, 16'd10751};
    foreach (directed_edges[i]) send_edge(directed_edges[i]);
    wait_quiet();

    // overlapping windows: leader beats repeat, zero beats one
    set_timing(12000, 11600, 1500, 1800, 700);
    directed_edges = '{16'd0, 16'd11800, 16'd1650, 16'd1650, 16'd30000, 16'd11300};
    foreach (directed_edges[i]) send_edge(directed_edges[i]);
    wait_quiet();

    set_timing(LEADER_RST, REPEAT_RST, ZERO_RST, ONE_RST, TOLERANCE_RST);
    set_mode(IDLE_NONE);
    run_random(200, 1'b1);
    set_mode(IDLE_SENDER);
    run_random(150, 1'b0);

    set_timing(12000, 11600, 1500, 1800, 700);
    set_mode(IDLE_RECEIVER);
    run_random(150, 1'b0);

    // timings at the ends of the range
    set_timing(CNT_MAX, 0, 1, CNT_MAX - 1, 3);
    set_mode(IDLE_BOTH);
    run_random(150, 1'b0);

    set_timing(0, 0, 0, 0, CNT_MAX);
    set_mode(IDLE_SENDER);
    run_random(80, 1'b0);

    // zero tolerance: nothing can ever match
    set_timing(LEADER_RST, REPEAT_RST, ZERO_RST, ONE_RST, 0);
    set_mode(IDLE_RECEIVER);
    run_random(60, 1'b0);

    for (int k = 0; k < 4; k++) begin
      set_timing($urandom_range(9000, 20000), $urandom_range(7000, 12000),
                 $urandom_range(300, 1500), $urandom_range(1600, 4000),
                 $urandom_range(1, 700));
      set_mode(idle_mode_t'(k));
      run_random(50, 1'b0);
    end

    $display("sent %0d edges over %0d register writes; checked %0d frame and %0d repeat results",
             items_sent, cfg_writes, sb.frames_seen, sb.repeats_seen);
    $display("input held off for %0d cycles during %0d long result stalls",
             full_cycles, holds_done);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.mismatches,
               sb.pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
